[src/assert_macros.svh]
// assertion helpers used by the port checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, muted while reset is asserted
`define RSR_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

// clocked assertion that also holds during reset
`define RSR_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("%m: assertion failed");

`endif

[src/rsr_pkg.sv]
// ----------------------------------------------------------------------------
// rsr_pkg
// Shared types and character codes of the raw string escape rewriter.
// ----------------------------------------------------------------------------
package rsr_pkg;

	localparam int CharW = 16;
	localparam int MaxRes = 3;

	localparam logic [CharW-1:0] ChAt = 16'h0040;
	localparam logic [CharW-1:0] ChSq = 16'h0027;
	localparam logic [CharW-1:0] ChDq = 16'h0022;
	localparam logic [CharW-1:0] ChBs = 16'h005C;
	localparam logic [CharW-1:0] ChSl = 16'h002F;
	localparam logic [CharW-1:0] ChSt = 16'h002A;
	localparam logic [CharW-1:0] ChNl = 16'h000A;

	typedef struct packed {
		logic [CharW-1:0] text_char;
		logic             text_end;
	} text_t;

	typedef struct packed {
		logic [CharW-1:0] out_char;
		logic             run_last;
		logic             text_done;
	} res_t;

	// results caused by one input transaction
	typedef struct packed {
		logic [1:0]                   cnt;
		logic [MaxRes-1:0][CharW-1:0] chars;
		logic                         done;
	} grp_t;

endpackage

[src/raw_string_escape_rewriter.sv]
// ----------------------------------------------------------------------------
// raw_string_escape_rewriter
// Rewrites script text so that raw strings become ordinary escaped strings.
// ----------------------------------------------------------------------------
// Input channel text (text_valid/text_stall) takes one 16-bit character per
// transaction with text_end on the final character of a text. The block holds
// one character back as lookahead, so the first character of a text, and one
// that follows a raw opener or an escaped quote pair, makes no result unless
// it ends the text; any other makes one to three results on the res channel
// (res_valid/res_stall), which carry run_last on the last result of that input
// and text_done on the final character of the rewritten text.
// Results are registered: they appear in the cycle after the input transaction
// that causes them. One input per cycle while each input makes at most one
// result and res_stall is low; an input that makes two or three results holds
// the result register, and text_stall is raised, until its last result is taken.
// A stalled receiver holds res steady and backs up into text_stall within
// the same cycle. Reset puts the lexer in plain code mode with nothing held and
// empties the result register; each text_end returns the lexer to that state.
module raw_string_escape_rewriter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           text_valid,
	output logic           text_stall,
	input  rsr_pkg::text_t text,
	output logic           res_valid,
	input  logic           res_stall,
	output rsr_pkg::res_t  res
);
	import rsr_pkg::*;

	grp_t grp;
	logic free;
	logic take;

	assign text_stall = !free;
	assign take       = text_valid && free;

	rsr_lex u_lex (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.text   (text),
		.grp    (grp)
	);

	rsr_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && grp.cnt != 2'd0),
		.grp       (grp),
		.free      (free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

[src/rsr_lex.sv]
// ----------------------------------------------------------------------------
// rsr_lex
// Lexer state with one-character lookahead; builds the result group of each
// accepted transaction.
// ----------------------------------------------------------------------------
module rsr_lex (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  rsr_pkg::text_t text,
	output rsr_pkg::grp_t  grp
);
	import rsr_pkg::*;

	typedef enum logic [2:0] {
		M_PLAIN = 3'd0,
		M_SQ    = 3'd1,
		M_DQ    = 3'd2,
		M_RAW   = 3'd3,
		M_LINE  = 3'd4,
		M_BLOCK = 3'd5
	} mode_t;

	mode_t            mode_q;
	logic [CharW-1:0] held_q;
	logic             held_vld_q;

	mode_t            mode_d;
	logic [CharW-1:0] held_d;
	logic             held_vld_d;
	logic             consumed;
	logic [CharW-1:0] h;
	logic [CharW-1:0] a;

	assign h = held_q;
	assign a = text.text_char;

	always_comb begin
		mode_d     = mode_q;
		consumed   = 1'b0;
		grp        = '0;
		grp.done   = text.text_end;
		if (held_vld_q) begin
			case (mode_q)
				M_LINE, M_BLOCK: begin
					if (h == ChNl && mode_q == M_LINE)
						mode_d = M_PLAIN;
					else if (h == ChSt && a == ChSl && mode_q == M_BLOCK)
						mode_d = M_PLAIN;
					grp.chars[0] = h;
					grp.cnt      = 2'd1;
				end
				default: begin
					if (h == ChAt && a == ChSq && mode_q == M_PLAIN) begin
						mode_d       = M_RAW;
						grp.chars[0] = ChSq;
						grp.cnt      = 2'd1;
						consumed     = 1'b1;
					end else if (h == ChBs && mode_q == M_RAW) begin
						grp.chars[0] = ChBs;
						grp.chars[1] = ChBs;
						grp.cnt      = 2'd2;
					end else if (h == ChBs && ((a == ChSq && mode_q == M_SQ) ||
							(a == ChDq && mode_q == M_DQ))) begin
						// escaped quote passes as a pair and does not close
						grp.chars[0] = h;
						grp.chars[1] = a;
						grp.cnt      = 2'd2;
						consumed     = 1'b1;
					end else begin
						if (h == ChSq) begin
							if (mode_q == M_PLAIN)
								mode_d = M_SQ;
							else if (mode_q == M_SQ || mode_q == M_RAW)
								mode_d = M_PLAIN;
						end else if (h == ChDq) begin
							if (mode_q == M_PLAIN)
								mode_d = M_DQ;
							else if (mode_q == M_DQ)
								mode_d = M_PLAIN;
						end else if (h == ChSl && a == ChSl && mode_q == M_PLAIN) begin
							mode_d = M_LINE;
						end else if (h == ChSl && a == ChSt && mode_q == M_PLAIN) begin
							mode_d = M_BLOCK;
						end
						grp.chars[0] = h;
						grp.cnt      = 2'd1;
					end
				end
			endcase
		end

		held_d     = a;
		held_vld_d = 1'b1;
		if (text.text_end) begin
			if (!consumed) begin
				grp.chars[grp.cnt] = a;
				grp.cnt            = grp.cnt + 2'd1;
			end
			mode_d     = M_PLAIN;
			held_d     = '0;
			held_vld_d = 1'b0;
		end else if (consumed) begin
			held_d     = '0;
			held_vld_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_PLAIN;
			held_q     <= '0;
			held_vld_q <= 1'b0;
		end else if (take) begin
			mode_q     <= mode_d;
			held_q     <= held_d;
			held_vld_q <= held_vld_d;
		end
	end

endmodule

[src/rsr_emit.sv]
// ----------------------------------------------------------------------------
// rsr_emit
// Result register: holds one result group and hands it out one character
// per transaction.
// ----------------------------------------------------------------------------
module rsr_emit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  rsr_pkg::grp_t  grp,
	output logic          free,
	output logic          res_valid,
	input  logic          res_stall,
	output rsr_pkg::res_t  res
);
	import rsr_pkg::*;

	logic [1:0]                   cnt_q;
	logic [1:0]                   idx_q;
	logic [MaxRes-1:0][CharW-1:0] chars_q;
	logic                         done_q;
	logic                         last;
	logic                         take;

	assign res_valid = (idx_q != cnt_q);
	assign last      = (idx_q == cnt_q - 2'd1);
	assign take      = res_valid && !res_stall;
	// a new group may enter as the last character of the current one leaves
	assign free      = !res_valid || (take && last);

	assign res.out_char  = chars_q[idx_q];
	assign res.run_last  = last;
	assign res.text_done = last && done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= grp.cnt;
			idx_q <= '0;
		end else if (take) begin
			if (last) begin
				cnt_q <= '0;
				idx_q <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			chars_q <= grp.chars;
			done_q  <= grp.done;
		end
	end

endmodule

[src/rsr_checker.sv]
// ----------------------------------------------------------------------------
// rsr_port_checker
// Port-level checks of the raw string escape rewriter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rsr_port_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           text_stall,
	input logic           res_valid,
	input logic           res_stall,
	input rsr_pkg::res_t  res
);
	import rsr_pkg::*;

	// a stalled result stays and does not change
	`RSR_ASSERT(a_res_hold, clk, arst_n, res_valid && res_stall |=> res_valid && $stable(res))
	// end of text is always the last result of its transaction
	`RSR_ASSERT(a_done_last, clk, arst_n, res_valid && res.text_done |-> res.run_last)
	// more results of the same input follow right away
	`RSR_ASSERT(a_run_cont, clk, arst_n, res_valid && !res_stall && !res.run_last |=> res_valid)
	// no input is taken while a result group still has more than one to go
	`RSR_ASSERT(a_in_block, clk, arst_n, res_valid && !res.run_last |-> text_stall)
	// nothing is offered while reset stays asserted
	`RSR_ASSERT_ALWAYS(a_rst_idle, clk, !arst_n && $past(!arst_n) |-> !res_valid)

endmodule

bind raw_string_escape_rewriter rsr_port_checker u_rsr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.text_stall (text_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res        (res)
);

[dv/rsr_checker.sv]
// ----------------------------------------------------------------------------
// rsr_checker
// Watches both channels of the raw string escape rewriter. It predicts the
// rewritten characters of every input transaction and compares each result
// transaction, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module rsr_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           text_valid,
	input  logic           text_stall,
	input  rsr_pkg::text_t text,
	input  logic           res_valid,
	input  logic           res_stall,
	input  rsr_pkg::res_t  res,
	output int             fail_cnt,
	output int             n_pending
);
	import rsr_pkg::*;

	typedef enum logic [2:0] {
		LexPlain,
		LexSq,
		LexDq,
		LexRaw,
		LexLine,
		LexBlock
	} lex_e;

	lex_e             lex_mode;
	logic [CharW-1:0] look_char;
	logic             look_valid;
	res_t             rewritten_q[$];
	int               mism = 0;

	assign fail_cnt = mism;

	// rewrite one input character against the held lookahead
	task automatic rewrite_char(input text_t it);
		logic [CharW-1:0] outs [MaxRes];
		logic [CharW-1:0] h;
		logic [CharW-1:0] a;
		int               n;
		logic             taken;
		res_t             r;
		n = 0;
		taken = 1'b0;
		h = look_char;
		a = it.text_char;
		if (look_valid) begin
			if (lex_mode == LexLine || lex_mode == LexBlock) begin
				if (h == ChNl && lex_mode == LexLine)
					lex_mode = LexPlain;
				else if (h == ChSt && a == ChSl && lex_mode == LexBlock)
					lex_mode = LexPlain;
				outs[n] = h;
				n++;
			end else if (h == ChAt && a == ChSq && lex_mode == LexPlain) begin
				// raw string opener: only the quote survives
				lex_mode = LexRaw;
				outs[n] = ChSq;
				n++;
				taken = 1'b1;
			end else if (h == ChBs && lex_mode == LexRaw) begin
				outs[n] = ChBs;
				n++;
				outs[n] = ChBs;
				n++;
			end else if (h == ChBs && ((a == ChSq && lex_mode == LexSq) ||
					(a == ChDq && lex_mode == LexDq))) begin
				// escaped quote travels as a pair and does not close the string
				outs[n] = h;
				n++;
				outs[n] = a;
				n++;
				taken = 1'b1;
			end else begin
				if (h == ChSq) begin
					if (lex_mode == LexPlain)
						lex_mode = LexSq;
					else if (lex_mode == LexSq || lex_mode == LexRaw)
						lex_mode = LexPlain;
				end else if (h == ChDq) begin
					if (lex_mode == LexPlain)
						lex_mode = LexDq;
					else if (lex_mode == LexDq)
						lex_mode = LexPlain;
				end else if (h == ChSl && lex_mode == LexPlain) begin
					if (a == ChSl)
						lex_mode = LexLine;
					else if (a == ChSt)
						lex_mode = LexBlock;
				end
				outs[n] = h;
				n++;
			end
		end
		if (it.text_end) begin
			if (!taken) begin
				outs[n] = a;
				n++;
			end
			lex_mode = LexPlain;
			look_valid = 1'b0;
			look_char = '0;
		end else if (taken) begin
			look_valid = 1'b0;
			look_char = '0;
		end else begin
			look_char = a;
			look_valid = 1'b1;
		end
		for (int i = 0; i < n; i++) begin
			r.out_char = outs[i];
			r.run_last = (i == n - 1);
			r.text_done = (i == n - 1) && it.text_end;
			rewritten_q.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		if (!arst_n) begin
			lex_mode = LexPlain;
			look_char = '0;
			look_valid = 1'b0;
			rewritten_q.delete();
			n_pending <= 0;
		end else begin
			// results are never offered in the same cycle as their input, so compare before predicting
			if (res_valid && !res_stall) begin
				if (rewritten_q.size() == 0) begin
					$error("unexpected result transaction: out_char %h", res.out_char);
					mism++;
				end else begin
					want = rewritten_q.pop_front();
					if (res.out_char !== want.out_char) begin
						$error("out_char: expected %h, got %h", want.out_char, res.out_char);
						mism++;
					end
					if (res.run_last !== want.run_last) begin
						$error("run_last: expected %b, got %b", want.run_last, res.run_last);
						mism++;
					end
					if (res.text_done !== want.text_done) begin
						$error("text_done: expected %b, got %b", want.text_done,
							res.text_done);
						mism++;
					end
				end
			end
			if (text_valid && !text_stall)
				rewrite_char(text);
			n_pending <= rewritten_q.size();
		end
	end

endmodule

[dv/tb_raw_string_escape_rewriter.sv]
// ----------------------------------------------------------------------------
// tb_raw_string_escape_rewriter
// Drives script texts into the rewriter: a few hand-made texts covering raw
// strings, escaped quotes and comments, then random texts built from string
// and comment fragments with noise and truncation. Both sides idle at random;
// the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_raw_string_escape_rewriter;
	import rsr_pkg::*;

	localparam logic [CharW-1:0] ChLowA = 16'h0061;
	localparam int HoldCycles = 80;
	localparam int RandItems = 300;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             text_valid;
	logic             text_stall;
	text_t            text;
	logic             res_valid;
	logic             res_stall;
	res_t             res;
	int               fail_cnt;
	int               n_pending;
	bit               idle_on;
	bit               hold_req;
	int               n_items;
	logic [CharW-1:0] chars_q[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	raw_string_escape_rewriter u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text       (text),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res)
	);

	rsr_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text       (text),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.res        (res),
		.fail_cnt   (fail_cnt),
		.n_pending  (n_pending)
	);

	// mostly lexer-relevant characters, some letters, some arbitrary code units
	function automatic logic [CharW-1:0] pick_char();
		case ($urandom_range(0, 9))
			0: return ChAt;
			1: return ChSq;
			2: return ChDq;
			3: return ChBs;
			4: return ChSl;
			5: return ChSt;
			6: return ChNl;
			7, 8: return ChLowA + CharW'($urandom_range(0, 25));
			default: return CharW'($urandom());
		endcase
	endfunction

	task automatic build_text();
		int n;
		chars_q.delete();
		repeat ($urandom_range(1, 4)) begin
			case ($urandom_range(0, 6))
				0: begin
					chars_q.push_back(ChAt);
					chars_q.push_back(ChSq);
					repeat ($urandom_range(0, 4))
						chars_q.push_back($urandom_range(0, 1) ? ChBs : pick_char());
					chars_q.push_back(ChSq);
				end
				1, 2: begin
					logic [CharW-1:0] q;
					q = $urandom_range(0, 1) ? ChSq : ChDq;
					chars_q.push_back(q);
					repeat ($urandom_range(0, 3)) begin
						if ($urandom_range(0, 1)) begin
							chars_q.push_back(ChBs);
							chars_q.push_back(q);
						end else begin
							chars_q.push_back(pick_char());
						end
					end
					chars_q.push_back(q);
				end
				3: begin
					chars_q.push_back(ChSl);
					chars_q.push_back(ChSl);
					repeat ($urandom_range(0, 3))
						chars_q.push_back(pick_char());
					chars_q.push_back(ChNl);
				end
				4: begin
					chars_q.push_back(ChSl);
					chars_q.push_back(ChSt);
					repeat ($urandom_range(0, 3))
						chars_q.push_back(pick_char());
					chars_q.push_back(ChSt);
					chars_q.push_back(ChSl);
				end
				default: begin
					repeat ($urandom_range(1, 3))
						chars_q.push_back(pick_char());
				end
			endcase
		end
		// broken text: cut off somewhere inside
		if ($urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, chars_q.size());
			while (chars_q.size() > n)
				void'(chars_q.pop_back());
		end
	endtask

	task automatic send_item(input logic [CharW-1:0] ch, input logic last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			text_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		text.text_char <= ch;
		text.text_end <= last;
		text_valid <= 1'b1;
		@(posedge clk);
		while (text_stall) @(posedge clk);
		n_items++;
	endtask

	task automatic send_text();
		for (int i = 0; i < chars_q.size(); i++)
			send_item(chars_q[i], i == chars_q.size() - 1);
	endtask

	// result side: random stall bursts, plus one long hold-off on request
	initial begin : res_side
		res_stall = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				res_stall <= 1'b1;
				repeat (HoldCycles) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 2) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
			res_stall <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	initial begin : stimulus
		bit held_off;
		bit paused;
		arst_n = 1'b0;
		text_valid = 1'b0;
		text = '0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		n_items = 0;
		held_off = 1'b0;
		paused = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single character text, all ones
		chars_q = '{16'hFFFF};
		send_text();
		// raw backslash with the end as lookahead: three results from one item
		chars_q = '{ChAt, ChSq, ChBs, ChBs};
		send_text();
		// escaped quote swallows the final character
		chars_q = '{ChSq, ChLowA, ChBs, ChSq};
		send_text();
		chars_q = '{ChDq, ChBs, ChDq, 16'h0000, ChDq};
		send_text();
		// block comment, then line comment closed by newline
		chars_q = '{ChSl, ChSt, ChSt, ChSl, ChSl, ChSl, ChNl, 16'h0000};
		send_text();
		// raw opener ending the text
		chars_q = '{ChAt, ChSq};
		send_text();

		while (n_items < RandItems) begin
			if (n_items > RandItems - 60)
				idle_on = 1'b0;
			build_text();
			send_text();
			if (!held_off && n_items > 100) begin
				hold_req = 1'b1;
				held_off = 1'b1;
			end
			if (!paused && n_items > 180) begin
				// let the block drain completely before going on
				text_valid <= 1'b0;
				@(posedge clk);
				wait (n_pending == 0);
				paused = 1'b1;
			end
		end

		text_valid <= 1'b0;
		@(posedge clk);
		wait (n_pending == 0);
		repeat (10) @(posedge clk);
		if (fail_cnt == 0)
			$display("tb_raw_string_escape_rewriter: PASS");
		else
			$display("tb_raw_string_escape_rewriter: FAIL");
		$finish;
	end

	initial begin : watchdog
		#2000000;
		$display("tb_raw_string_escape_rewriter: FAIL");
		$finish;
	end

endmodule
